// ===== design/fms_pkg.sv =====
package fms_pkg;

    localparam int unsigned HEIGHT_W   = 20;
    localparam int unsigned CLIMB_W    = 16;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned SUM_W      = HEIGHT_W + 2;

    localparam logic [CLIMB_W-1:0] TAKEOFF_HEIGHT_RST = 16'd1000;
    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST    = 16'd100;

    localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF_HEIGHT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 8'd1;

    localparam logic [2:0] MODE_READY   = 3'd0;
    localparam logic [2:0] MODE_TAKEOFF = 3'd1;
    localparam logic [2:0] MODE_HOVER   = 3'd2;
    localparam logic [2:0] MODE_PILOT   = 3'd3;
    localparam logic [2:0] MODE_CMD     = 3'd4;
    localparam logic [2:0] MODE_LAND    = 3'd5;

    localparam logic [2:0] SRC_ODOM       = 3'd0;
    localparam logic [2:0] SRC_HOVER_POSE = 3'd1;
    localparam logic [2:0] SRC_COMMAND    = 3'd2;
    localparam logic [2:0] SRC_STICKS     = 3'd3;
    localparam logic [2:0] SRC_START_POSE = 3'd4;

    localparam logic [2:0] REFUSE_NONE      = 3'd0;
    localparam logic [2:0] REFUSE_NO_ODOM   = 3'd1;
    localparam logic [2:0] REFUSE_CMD_ACT   = 3'd2;
    localparam logic [2:0] REFUSE_NO_RC     = 3'd3;
    localparam logic [2:0] REFUSE_MOVING    = 3'd4;
    localparam logic [2:0] REFUSE_SWITCH    = 3'd5;

    // packed MSB first: the last member sits in bit 0
    typedef struct packed {
        logic                       switch_ok;
        logic signed [HEIGHT_W-1:0] height_mm;
        logic                       on_ground;
        logic                       vehicle_armed;
        logic                       sticks_centered;
        logic                       stick_throttle_up;
        logic                       land_request;
        logic                       takeoff_request;
        logic [SPEED_W-1:0]         speed_mm_s;
        logic                       rc_fresh;
        logic                       cmd_fresh;
        logic                       odom_fresh;
    } t_in_item;

    typedef struct packed {
        logic [2:0] refuse_code;
        logic       start_trigger;
        logic       disarm_request;
        logic       capture_start;
        logic       capture_hover;
        logic [2:0] setpoint_source;
        logic [2:0] mode;
    } t_out_item;

    localparam int unsigned IN_ITEM_W  = $bits(t_in_item);
    localparam int unsigned OUT_ITEM_W = $bits(t_out_item);

endpackage

// ===== design/flight_mode_sequencer_core.sv =====
// Channel   | Dir | Beat fields
// s_axis    | in  | tdata: odom_fresh, cmd_fresh, rc_fresh, speed_mm_s, takeoff_request,
//           |     |   land_request, stick_throttle_up, sticks_centered, vehicle_armed,
//           |     |   on_ground, height_mm, switch_ok
// m_axis    | out | tdata: mode, setpoint_source, capture_hover, capture_start,
//           |     |   disarm_request, start_trigger, refuse_code
// cfg       | in  | index 0 takeoff_height_mm, index 1 static_speed_limit_mm_s
//
// One beat per cycle sustained unless the output stalls; each beat goes from input to output:
// input register, then one pass of mode logic into the result register.
// The mode state advances as a beat moves from the input register to the result register.
// Synchronous active-low reset clears mode, start height and trigger flag,
// and restores the config registers to their defaults.
// An output stall holds the result register and fills the input register, then backs up.
module flight_mode_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [0] odom_fresh [1] cmd_fresh [2] rc_fresh [18:3] speed_mm_s [19] takeoff_request
    // [20] land_request [21] stick_throttle_up [22] sticks_centered [23] vehicle_armed
    // [24] on_ground [44:25] height_mm [45] switch_ok [47:46] zero
    input  logic [fms_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [2:0] mode [5:3] setpoint_source [6] capture_hover [7] capture_start
    // [8] disarm_request [9] start_trigger [12:10] refuse_code [15:13] zero
    output logic [fms_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fms_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fms_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        ST_READY   = fms_pkg::MODE_READY,
        ST_TAKEOFF = fms_pkg::MODE_TAKEOFF,
        ST_HOVER   = fms_pkg::MODE_HOVER,
        ST_PILOT   = fms_pkg::MODE_PILOT,
        ST_CMD     = fms_pkg::MODE_CMD,
        ST_LAND    = fms_pkg::MODE_LAND
    } t_mode;

    t_mode                                   r_mode, n_mode;
    logic signed [fms_pkg::HEIGHT_W-1:0]     r_start_height, n_start_height;
    logic                                    r_trigger_sent, n_trigger_sent;
    logic [fms_pkg::CLIMB_W-1:0]             r_takeoff_height;
    logic [fms_pkg::SPEED_W-1:0]             r_speed_limit;

    logic                                    r_in_vld;
    fms_pkg::t_in_item                       r_in;
    logic                                    r_out_vld;
    fms_pkg::t_out_item                      r_out, n_out;

    logic                                    advance;
    logic signed [fms_pkg::SUM_W-1:0]        target_height;
    logic signed [fms_pkg::SUM_W-1:0]        height_ext;
    logic                                    climb_done;
    logic                                    takeoff_go;

    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(fms_pkg::OUT_DATA_W - fms_pkg::OUT_ITEM_W){1'b0}}, r_out};

    assign target_height = $signed({{2{r_start_height[fms_pkg::HEIGHT_W-1]}}, r_start_height})
                         + $signed({{(fms_pkg::SUM_W - fms_pkg::CLIMB_W){1'b0}},
                                    r_takeoff_height});
    assign height_ext    = $signed({{2{r_in.height_mm[fms_pkg::HEIGHT_W-1]}}, r_in.height_mm});
    assign climb_done    = height_ext >= target_height;
    assign takeoff_go    = r_in.takeoff_request || (r_in.stick_throttle_up && r_in.vehicle_armed);

    always_comb begin
        n_mode          = r_mode;
        n_start_height  = r_start_height;
        n_trigger_sent  = r_trigger_sent;
        n_out           = '0;
        unique case (r_mode)
            ST_READY: begin
                priority if (!r_in.odom_fresh) begin
                    n_out.refuse_code = fms_pkg::REFUSE_NO_ODOM;
                end else if (r_in.cmd_fresh) begin
                    n_out.refuse_code = fms_pkg::REFUSE_CMD_ACT;
                end else if (!r_in.rc_fresh) begin
                    n_out.refuse_code = fms_pkg::REFUSE_NO_RC;
                end else if (r_in.speed_mm_s > r_speed_limit) begin
                    n_out.refuse_code = fms_pkg::REFUSE_MOVING;
                end else if (takeoff_go) begin
                    if (!r_in.switch_ok) begin
                        n_out.refuse_code = fms_pkg::REFUSE_SWITCH;
                    end else begin
                        n_mode              = ST_TAKEOFF;
                        n_start_height      = r_in.height_mm;
                        n_out.capture_start = 1'b1;
                        n_trigger_sent      = 1'b0;
                    end
                end else begin
                    n_out.refuse_code = fms_pkg::REFUSE_NONE;
                end
            end
            ST_TAKEOFF: begin
                if (climb_done) begin
                    n_mode              = ST_HOVER;
                    n_out.capture_hover = 1'b1;
                end else begin
                    n_out.setpoint_source = fms_pkg::SRC_START_POSE;
                end
            end
            ST_HOVER: begin
                priority if (r_in.cmd_fresh) begin
                    n_mode = ST_CMD;
                end else if (r_in.land_request) begin
                    n_mode              = ST_LAND;
                    n_start_height      = r_in.height_mm;
                    n_out.capture_start = 1'b1;
                end else if (!r_in.sticks_centered) begin
                    n_mode = ST_PILOT;
                end else begin
                    n_out.setpoint_source = fms_pkg::SRC_HOVER_POSE;
                    n_out.start_trigger   = !r_trigger_sent;
                    n_trigger_sent        = 1'b1;
                end
            end
            ST_PILOT: begin
                priority if (r_in.sticks_centered) begin
                    n_mode              = ST_HOVER;
                    n_out.capture_hover = 1'b1;
                end else if (r_in.on_ground && r_in.vehicle_armed) begin
                    n_mode = ST_READY;
                end else begin
                    n_out.setpoint_source = fms_pkg::SRC_STICKS;
                end
            end
            ST_CMD: begin
                priority if (!r_in.cmd_fresh) begin
                    n_mode              = ST_HOVER;
                    n_out.capture_hover = 1'b1;
                end else if (!r_in.sticks_centered) begin
                    n_mode = ST_PILOT;
                end else begin
                    n_out.setpoint_source = fms_pkg::SRC_COMMAND;
                end
            end
            ST_LAND: begin
                if (r_in.on_ground) begin
                    n_out.disarm_request = 1'b1;
                    n_mode               = ST_READY;
                end else begin
                    n_out.setpoint_source = fms_pkg::SRC_START_POSE;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        n_out.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= ST_READY;
            r_start_height   <= '0;
            r_trigger_sent   <= 1'b0;
            r_takeoff_height <= fms_pkg::TAKEOFF_HEIGHT_RST;
            r_speed_limit    <= fms_pkg::SPEED_LIMIT_RST;
            r_in_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == fms_pkg::REG_TAKEOFF_HEIGHT) begin
                    r_takeoff_height <= i_cfg_data;
                end
                if (i_cfg_index == fms_pkg::REG_SPEED_LIMIT) begin
                    r_speed_limit <= i_cfg_data;
                end
            end
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_mode         <= n_mode;
                r_start_height <= n_start_height;
                r_trigger_sent <= n_trigger_sent;
                r_out_vld      <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= fms_pkg::t_in_item'(i_s_axis_tdata[fms_pkg::IN_ITEM_W-1:0]);
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== design/fms_checker.sv =====
module fms_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [fms_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    fms_pkg::t_out_item beat;

    assign beat = fms_pkg::t_out_item'(o_m_axis_tdata[fms_pkg::OUT_ITEM_W-1:0]);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    a_refuse_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (beat.refuse_code != fms_pkg::REFUSE_NONE)
        |-> beat.mode == fms_pkg::MODE_READY)
        else $error("refusal reported outside ready");

    a_capture_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && beat.capture_start
        |-> (beat.mode == fms_pkg::MODE_TAKEOFF || beat.mode == fms_pkg::MODE_LAND)
            && beat.setpoint_source == fms_pkg::SRC_ODOM)
        else $error("start capture without entering takeoff or land");

    a_trigger_hover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && beat.start_trigger
        |-> beat.mode == fms_pkg::MODE_HOVER
            && beat.setpoint_source == fms_pkg::SRC_HOVER_POSE)
        else $error("start trigger outside a quiet hover tick");

    a_disarm_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && beat.disarm_request |-> beat.mode == fms_pkg::MODE_READY)
        else $error("disarm request without return to ready");

endmodule

bind flight_mode_sequencer_core fms_checker u_fms_checker (.*);

// ===== tb/flight_mode_sequencer_core_test.sv =====
module flight_mode_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fms_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    flight_mode_sequencer_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // sequencer copy: configuration and state
    logic [CLIMB_W-1:0]         cfg_climb_mm  = TAKEOFF_HEIGHT_RST;
    logic [SPEED_W-1:0]         cfg_speed_lim = SPEED_LIMIT_RST;
    logic [2:0]                 seq_mode      = MODE_READY;
    logic signed [HEIGHT_W-1:0] seq_start_h   = '0;
    logic                       seq_trig_sent = 1'b0;

    t_out_item mode_reports[$];

    int  fails      = 0;
    int  cycles     = 0;
    int  n_ticks    = 0;
    int  n_settings = 0;
    int  n_takeoffs = 0;
    int  n_disarms  = 0;
    int  n_triggers = 0;
    bit  calm       = 1'b0;
    int  stall_left = 0;

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic t_out_item step_sequencer(t_in_item t);
        t_out_item r;
        int        h;
        int        goal;
        r    = '0;
        h    = int'($signed(t.height_mm));
        goal = int'($signed(seq_start_h)) + int'(cfg_climb_mm);
        case (seq_mode)
            MODE_READY: begin
                if (!t.odom_fresh) begin
                    r.refuse_code = REFUSE_NO_ODOM;
                end else if (t.cmd_fresh) begin
                    r.refuse_code = REFUSE_CMD_ACT;
                end else if (!t.rc_fresh) begin
                    r.refuse_code = REFUSE_NO_RC;
                end else if (t.speed_mm_s > cfg_speed_lim) begin
                    r.refuse_code = REFUSE_MOVING;
                end else if (t.takeoff_request || (t.stick_throttle_up && t.vehicle_armed)) begin
                    if (!t.switch_ok) begin
                        r.refuse_code = REFUSE_SWITCH;
                    end else begin
                        seq_mode        = MODE_TAKEOFF;
                        seq_start_h     = t.height_mm;
                        r.capture_start = 1'b1;
                        seq_trig_sent   = 1'b0;
                    end
                end
            end
            MODE_TAKEOFF: begin
                if (h >= goal) begin
                    seq_mode        = MODE_HOVER;
                    r.capture_hover = 1'b1;
                end else begin
                    r.setpoint_source = SRC_START_POSE;
                end
            end
            MODE_HOVER: begin
                if (t.cmd_fresh) begin
                    seq_mode = MODE_CMD;
                end else if (t.land_request) begin
                    seq_mode        = MODE_LAND;
                    seq_start_h     = t.height_mm;
                    r.capture_start = 1'b1;
                end else if (!t.sticks_centered) begin
                    seq_mode = MODE_PILOT;
                end else begin
                    r.setpoint_source = SRC_HOVER_POSE;
                    if (!seq_trig_sent) begin
                        r.start_trigger = 1'b1;
                        seq_trig_sent   = 1'b1;
                    end
                end
            end
            MODE_PILOT: begin
                if (t.sticks_centered) begin
                    seq_mode        = MODE_HOVER;
                    r.capture_hover = 1'b1;
                end else if (t.on_ground && t.vehicle_armed) begin
                    seq_mode = MODE_READY;
                end else begin
                    r.setpoint_source = SRC_STICKS;
                end
            end
            MODE_CMD: begin
                if (!t.cmd_fresh) begin
                    seq_mode        = MODE_HOVER;
                    r.capture_hover = 1'b1;
                end else if (!t.sticks_centered) begin
                    seq_mode = MODE_PILOT;
                end else begin
                    r.setpoint_source = SRC_COMMAND;
                end
            end
            MODE_LAND: begin
                if (t.on_ground) begin
                    r.disarm_request = 1'b1;
                    seq_mode         = MODE_READY;
                end else begin
                    r.setpoint_source = SRC_START_POSE;
                end
            end
            default: begin
            end
        endcase
        r.mode = seq_mode;
        return r;
    endfunction

    task automatic send_tick(t_in_item t);
        t_out_item r;
        if (!calm && chance(25)) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_DATA_W - IN_ITEM_W){1'b0}}, t};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = step_sequencer(t);
        mode_reports.push_back(r);
        n_ticks++;
        if (r.capture_start && r.mode == MODE_TAKEOFF) n_takeoffs++;
        if (r.disarm_request) n_disarms++;
        if (r.start_trigger) n_triggers++;
    endtask

    // hold off until the pipeline is empty
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (mode_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limits(logic [CLIMB_W-1:0] climb, logic [SPEED_W-1:0] lim);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_TAKEOFF_HEIGHT;
        i_cfg_data  <= climb;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_climb_mm = climb;
        i_cfg_index <= REG_SPEED_LIMIT;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_speed_lim = lim;
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic t_in_item ready_tick();
        t_in_item t;
        t                 = '0;
        t.odom_fresh      = 1'b1;
        t.rc_fresh        = 1'b1;
        t.sticks_centered = 1'b1;
        t.switch_ok       = 1'b1;
        return t;
    endfunction

    function automatic t_in_item random_tick();
        t_in_item t;
        int       h;
        t                   = '0;
        t.odom_fresh        = chance(90);
        case (seq_mode)
            MODE_READY: t.cmd_fresh = chance(10);
            MODE_HOVER: t.cmd_fresh = chance(15);
            MODE_CMD:   t.cmd_fresh = chance(80);
            default:    t.cmd_fresh = chance(30);
        endcase
        t.rc_fresh          = chance(90);
        t.speed_mm_s        = chance(70) ? SPEED_W'($urandom_range(0, cfg_speed_lim))
                                         : SPEED_W'($urandom);
        t.takeoff_request   = chance(40);
        t.land_request      = chance(20);
        t.stick_throttle_up = chance(20);
        t.sticks_centered   = chance(70);
        t.vehicle_armed     = chance(50);
        t.on_ground         = chance(30);
        t.switch_ok         = chance(85);
        if (seq_mode == MODE_TAKEOFF && chance(50)) begin
            h = int'($signed(seq_start_h)) + int'(cfg_climb_mm) + $urandom_range(0, 4) - 2;
            if (h > 524287) h = 524287;
            if (h < -524288) h = -524288;
            t.height_mm = HEIGHT_W'(h);
        end else begin
            t.height_mm = HEIGHT_W'($urandom);
        end
        return t;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[OUT_ITEM_W-1:0];
            if (mode_reports.size() == 0) begin
                $error("result beat with no tick pending: %h", o_m_axis_tdata);
                fails++;
            end else begin
                want = mode_reports.pop_front();
                check_field("mode", int'(want.mode), int'(got.mode));
                check_field("setpoint_source", int'(want.setpoint_source),
                            int'(got.setpoint_source));
                check_field("capture_hover", int'(want.capture_hover),
                            int'(got.capture_hover));
                check_field("capture_start", int'(want.capture_start),
                            int'(got.capture_start));
                check_field("disarm_request", int'(want.disarm_request),
                            int'(got.disarm_request));
                check_field("start_trigger", int'(want.start_trigger),
                            int'(got.start_trigger));
                check_field("refuse_code", int'(want.refuse_code), int'(got.refuse_code));
                check_field("pad", 0, int'(o_m_axis_tdata[OUT_DATA_W-1:OUT_ITEM_W]));
            end
        end
    end

    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (chance(20)) begin
            stall_left = $urandom_range(1, 5) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("flight_mode_sequencer_core test failed");
            $finish;
        end
    end

    task automatic test_ready_refusals;
        t_in_item t;
        t = ready_tick(); t.odom_fresh = 1'b0; t.takeoff_request = 1'b1; send_tick(t);
        t = ready_tick(); t.cmd_fresh = 1'b1; send_tick(t);
        t = ready_tick(); t.rc_fresh = 1'b0; send_tick(t);
        t = ready_tick(); t.speed_mm_s = 16'd101; t.takeoff_request = 1'b1; send_tick(t);
        t = ready_tick(); t.speed_mm_s = 16'd100; t.takeoff_request = 1'b1;
        t.switch_ok = 1'b0; send_tick(t);
        t = ready_tick(); send_tick(t);
    endtask

    task automatic test_climb_and_hover;
        t_in_item t;
        t = ready_tick(); t.takeoff_request = 1'b1; t.height_mm = -20'sd524288; send_tick(t);
        t = ready_tick(); t.height_mm = -20'sd523289; send_tick(t);
        t = ready_tick(); t.height_mm = -20'sd523288; send_tick(t);
        t = ready_tick(); send_tick(t);
        t = ready_tick(); send_tick(t);
    endtask

    task automatic test_handover_and_landing;
        t_in_item t;
        t = ready_tick(); t.cmd_fresh = 1'b1; send_tick(t);
        t = ready_tick(); t.cmd_fresh = 1'b1; send_tick(t);
        t = ready_tick(); t.cmd_fresh = 1'b1; t.sticks_centered = 1'b0; send_tick(t);
        t = ready_tick(); t.sticks_centered = 1'b0; t.on_ground = 1'b1; send_tick(t);
        t = ready_tick(); send_tick(t);
        t = ready_tick(); send_tick(t);
        t = ready_tick(); t.land_request = 1'b1; t.height_mm = 20'sd12345; send_tick(t);
        t = ready_tick(); send_tick(t);
        t = ready_tick(); t.on_ground = 1'b1; send_tick(t);
    endtask

    task automatic test_height_extremes;
        t_in_item t;
        t = ready_tick(); t.stick_throttle_up = 1'b1; t.vehicle_armed = 1'b1;
        t.speed_mm_s = 16'd100; t.height_mm = 20'sd524287; send_tick(t);
        t = ready_tick(); t.height_mm = 20'sd524287; send_tick(t);
        write_limits(16'd0, 16'hFFFF);
        t = ready_tick(); t.height_mm = 20'sd524287; send_tick(t);
        t = ready_tick(); t.sticks_centered = 1'b0; send_tick(t);
        t = ready_tick(); t.sticks_centered = 1'b0; t.on_ground = 1'b1;
        t.vehicle_armed = 1'b1; send_tick(t);
        t = ready_tick(); t.speed_mm_s = 16'hFFFF; t.takeoff_request = 1'b1; send_tick(t);
    endtask

    task automatic test_random_flights(int n, logic [CLIMB_W-1:0] climb,
                                       logic [SPEED_W-1:0] lim);
        write_limits(climb, lim);
        repeat (n) send_tick(random_tick());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ready_refusals();
        test_climb_and_hover();
        test_handover_and_landing();
        test_height_extremes();
        test_random_flights(75, TAKEOFF_HEIGHT_RST, SPEED_LIMIT_RST);
        test_random_flights(75, 16'd0, 16'd0);
        test_random_flights(75, 16'hFFFF, 16'hFFFF);
        test_random_flights(75, CLIMB_W'($urandom_range(0, 3000)),
                            SPEED_W'($urandom_range(0, 500)));
        test_random_flights(75, CLIMB_W'($urandom), SPEED_W'($urandom));
        drain();
        calm = 1'b1;
        test_random_flights(75, 16'd500, 16'd200);
        drain();
        $display("covered %0d ticks over %0d register settings", n_ticks, n_settings);
        $display("takeoffs %0d, disarms %0d, start triggers %0d",
                 n_takeoffs, n_disarms, n_triggers);
        if (fails == 0) begin
            $display("flight_mode_sequencer_core test passed");
        end else begin
            $display("flight_mode_sequencer_core test failed");
        end
        $finish;
    end

endmodule
